/* rtl/arfp_pkg.sv */
// Shared constants, register indexes and the load bundle for the RTP/ALAC frame packer.
// No dependencies; used by arfp_serializer and alac_rtp_frame_packer.
package arfp_pkg;

    localparam int FRAMES_PER_PACKET = 352;

    // Largest payload byte count a packet may announce.
    localparam logic [15:0] MAX_BYTES = 16'(FRAMES_PER_PACKET * 4);

    // Width of the frames-left counter.
    localparam int FL_W = $clog2(FRAMES_PER_PACKET + 1);

    // Most bytes one transaction can produce: 12 RTP + 6 ALAC + flush.
    localparam int RESULTS_MAX = 19;
    localparam int CNT_W       = $clog2(RESULTS_MAX + 1);

    localparam logic [7:0] RTP_BYTE0  = 8'h80;
    localparam logic [7:0] RTP_BYTE1  = 8'h60;
    localparam logic [7:0] ALAC_BYTE0 = 8'h20;
    localparam logic [7:0] ALAC_BYTE1 = 8'h00;
    localparam logic [7:0] ALAC_BYTE2 = 8'h12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SSRC       = 2'd2;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    // Bytes of one transaction handed to the output shifter, byte 0 first.
    typedef struct packed {
        logic [RESULTS_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        flush;
    } t_load;

endpackage

/* rtl/arfp_serializer.sv */
// Output shift register: holds a transaction's bytes, sends one per cycle if ready.
// Depends on arfp_pkg (t_load, RESULTS_MAX, CNT_W).
module arfp_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load_en,
    input  arfp_pkg::t_load i_load,
    output logic           o_free,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_last
);
    import arfp_pkg::*;

    logic [RESULTS_MAX-1:0][7:0] r_buf;
    logic [RESULTS_MAX-1:0][7:0] n_buf;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            n_cnt;
    logic                        r_flush;
    logic                        n_flush;
    logic                        take;

    assign o_out_valid = (r_cnt != '0);
    assign take        = o_out_valid && i_out_ready;
    // Free when empty or when the final byte leaves in this cycle.
    assign o_free      = (r_cnt == '0) || (take && (r_cnt == CNT_W'(1)));
    assign o_out_byte  = r_buf[0];
    assign o_last      = r_flush && (r_cnt == CNT_W'(1));

    always_comb begin
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_flush = r_flush;
        if (i_load_en && o_free) begin
            n_buf   = i_load.bytes;
            n_cnt   = i_load.count;
            n_flush = i_load.flush;
        end else if (take) begin
            n_buf = {8'h00, r_buf[RESULTS_MAX-1:1]};
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_flush <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_flush <= n_flush;
        end
    end

endmodule

/* rtl/alac_rtp_frame_packer.sv */
// Top level of the RTP packetizer for uncompressed stereo ALAC audio.
// Depends on arfp_pkg and arfp_serializer.
//
// A start transaction (mode 0) produces the 12-byte RTP header and 6 bytes of the
// ALAC frame header, plus the closing byte when the clamped count holds no frame;
// each frame transaction (mode 1) produces its four sample bytes, shifted by 7 bits,
// and the closing byte with o_last on the final expected frame. Frames with no
// open packet produce nothing. All bytes of a transaction are formed in the cycle
// it is accepted and loaded into an output shift register that sends one byte per
// cycle while i_out_ready is high; the next input transaction is taken in the cycle
// the last byte leaves. Configuration writes load the sequence and timestamp
// counters or the ssrc and must only be issued while the block is idle.
module alac_rtp_frame_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [15:0]                    i_byte_count,
    input  logic [15:0]                    i_left_word,
    input  logic [15:0]                    i_right_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last,
    input  logic                           i_cfg_we,
    input  logic [arfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [arfp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import arfp_pkg::*;

    logic [15:0]     r_seq;
    logic [15:0]     n_seq;
    logic [31:0]     r_time;
    logic [31:0]     n_time;
    logic [31:0]     r_ssrc;
    logic [31:0]     n_ssrc;
    logic [6:0]      r_pend;
    logic [6:0]      n_pend;
    logic [FL_W-1:0] r_frames;
    logic [FL_W-1:0] n_frames;

    logic            in_accept;
    logic            load_en;
    t_load           load;
    logic            ser_free;

    assign o_in_ready = ser_free;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        logic [15:0]     cnt;
        logic [FL_W-1:0] frames;
        cnt      = (i_byte_count > MAX_BYTES) ? MAX_BYTES : i_byte_count;
        frames   = FL_W'(cnt >> 2);
        n_seq    = r_seq;
        n_time   = r_time;
        n_ssrc   = r_ssrc;
        n_pend   = r_pend;
        n_frames = r_frames;
        load_en  = 1'b0;
        load     = '0;

        if (in_accept) begin
            if (i_mode == MODE_START) begin
                load.bytes[0]  = RTP_BYTE0;
                load.bytes[1]  = RTP_BYTE1;
                load.bytes[2]  = r_seq[15:8];
                load.bytes[3]  = r_seq[7:0];
                load.bytes[4]  = r_time[31:24];
                load.bytes[5]  = r_time[23:16];
                load.bytes[6]  = r_time[15:8];
                load.bytes[7]  = r_time[7:0];
                load.bytes[8]  = r_ssrc[31:24];
                load.bytes[9]  = r_ssrc[23:16];
                load.bytes[10] = r_ssrc[15:8];
                load.bytes[11] = r_ssrc[7:0];
                load.bytes[12] = ALAC_BYTE0;
                load.bytes[13] = ALAC_BYTE1;
                load.bytes[14] = ALAC_BYTE2;
                load.bytes[15] = 8'h00;
                load.bytes[16] = {7'b0, cnt[15]};
                load.bytes[17] = cnt[14:7];
                load_en        = 1'b1;
                n_seq          = r_seq + 16'd1;
                n_time         = r_time + 32'(frames);
                n_frames       = frames;
                if (frames == '0) begin
                    // No frames follow: close the packet right away.
                    load.bytes[18] = {cnt[6:0], 1'b0};
                    load.count     = CNT_W'(19);
                    load.flush     = 1'b1;
                    n_pend         = 7'd0;
                end else begin
                    load.count = CNT_W'(18);
                    n_pend     = cnt[6:0];
                end
            end else if (r_frames != '0) begin
                load.bytes[0] = {r_pend, i_left_word[15]};
                load.bytes[1] = {i_left_word[14:8], i_left_word[7]};
                load.bytes[2] = {i_left_word[6:0], i_right_word[15]};
                load.bytes[3] = {i_right_word[14:8], i_right_word[7]};
                load_en       = 1'b1;
                n_frames      = r_frames - FL_W'(1);
                if (r_frames == FL_W'(1)) begin
                    load.bytes[4] = {i_right_word[6:0], 1'b0};
                    load.count    = CNT_W'(5);
                    load.flush    = 1'b1;
                    n_pend        = 7'd0;
                end else begin
                    load.count = CNT_W'(4);
                    n_pend     = i_right_word[6:0];
                end
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEQ_START:  n_seq  = i_cfg_data[15:0];
                CFG_TIME_START: n_time = i_cfg_data;
                CFG_SSRC:       n_ssrc = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= '0;
            r_time   <= '0;
            r_ssrc   <= '0;
            r_pend   <= '0;
            r_frames <= '0;
        end else begin
            r_seq    <= n_seq;
            r_time   <= n_time;
            r_ssrc   <= n_ssrc;
            r_pend   <= n_pend;
            r_frames <= n_frames;
        end
    end

    arfp_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_en   (load_en),
        .i_load      (load),
        .o_free      (ser_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    // A start transaction always shows the first RTP byte in the next cycle.
    a_start_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_mode == MODE_START) |=> o_out_valid && (o_out_byte == RTP_BYTE0))
        else $error("start transaction did not present the RTP header");

    // The closing byte only appears once no frames remain expected.
    a_last_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (r_frames == '0))
        else $error("last byte while frames still expected");

    // Input backpressure only while output bytes are pending.
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty output register");

endmodule
